// ===== design/iroc_pkg.sv =====
// Package for the impulse relay output controller.
// Holds register indexes, reset values and the structs shared between modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iroc_pkg;

    localparam int unsigned DEBOUNCE_W = 8;
    localparam int unsigned TICKS_W    = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned TIMER_BITS_DEFAULT = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF  = 2'd2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd25;
    localparam logic [TICKS_W-1:0]    PULSE_RESET    = 16'd200;
    localparam logic [TICKS_W-1:0]    HOLDOFF_RESET  = 16'd200;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic [TICKS_W-1:0]    pulse_ticks;
        logic [TICKS_W-1:0]    holdoff_ticks;
    } cfg_t;

    typedef struct packed {
        logic relay_drive;
        logic coil_write_valid;
        logic coil_write_value;
    } res_t;

    typedef struct packed {
        logic pulsing;
        logic holding_off;
    } status_t;

endpackage

`default_nettype wire

// ===== design/iroc_cfg.sv =====
// Configuration register file of the impulse relay output controller.
// Depends on iroc_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module iroc_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_en,
    input  wire logic [iroc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [iroc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output iroc_pkg::cfg_t                         cfg
);

    iroc_pkg::cfg_t cfg_reg;

    // Writes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= iroc_pkg::DEBOUNCE_RESET;
            cfg_reg.pulse_ticks    <= iroc_pkg::PULSE_RESET;
            cfg_reg.holdoff_ticks  <= iroc_pkg::HOLDOFF_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                iroc_pkg::REG_DEBOUNCE:
                    cfg_reg.debounce_ticks <= cfg_data[iroc_pkg::DEBOUNCE_W-1:0];
                iroc_pkg::REG_PULSE:
                    cfg_reg.pulse_ticks <= cfg_data[iroc_pkg::TICKS_W-1:0];
                iroc_pkg::REG_HOLDOFF:
                    cfg_reg.holdoff_ticks <= cfg_data[iroc_pkg::TICKS_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/iroc_step.sv =====
// Per-tick state and decision logic: debounce, relay mode, pulse and holdoff timers.
// Depends on iroc_pkg for cfg_t, res_t and status_t.
`timescale 1ns / 1ps
`default_nettype none

module iroc_step #(
    parameter int unsigned TIMER_BITS = iroc_pkg::TIMER_BITS_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step_en,
    input  wire logic       switch_coil,
    input  wire logic       mode_coil,
    input  wire logic       button_level,
    input  wire iroc_pkg::cfg_t cfg,
    output iroc_pkg::res_t  res,
    output iroc_pkg::status_t status
);

    localparam int unsigned CMP_W =
        (TIMER_BITS > iroc_pkg::TICKS_W) ? TIMER_BITS : iroc_pkg::TICKS_W;
    localparam logic [TIMER_BITS-1:0] TIMER_ONE = {{(TIMER_BITS-1){1'b0}}, 1'b1};

    logic                            debounced_level_reg, debounced_level_next;
    logic [iroc_pkg::DEBOUNCE_W-1:0] debounce_age_reg, debounce_age_next;
    logic                            relay_on_reg, relay_on_next;
    logic                            drive_level_reg, drive_level_next;
    logic                            pulsing_reg, pulsing_next;
    logic [TIMER_BITS-1:0]           pulse_elapsed_reg, pulse_elapsed_next;
    logic                            holding_off_reg, holding_off_next;
    logic [TIMER_BITS-1:0]           holdoff_elapsed_reg, holdoff_elapsed_next;

    logic                            take_level;
    logic                            pressed_now;
    logic                            write_valid;
    logic                            write_value;
    logic [iroc_pkg::DEBOUNCE_W-1:0] age_inc;

    always_comb
    begin
        debounced_level_next = debounced_level_reg;
        relay_on_next        = relay_on_reg;
        drive_level_next     = drive_level_reg;
        pulsing_next         = pulsing_reg;
        holding_off_next     = holding_off_reg;
        write_valid          = 1'b0;
        write_value          = 1'b0;

        // Running timers advance first and saturate at all ones.
        pulse_elapsed_next = pulse_elapsed_reg;
        if (pulsing_reg && !(&pulse_elapsed_reg))
            pulse_elapsed_next = pulse_elapsed_reg + TIMER_ONE;
        holdoff_elapsed_next = holdoff_elapsed_reg;
        if (holding_off_reg && !(&holdoff_elapsed_reg))
            holdoff_elapsed_next = holdoff_elapsed_reg + TIMER_ONE;

        // Lockout debounce: a new level is taken only once the window has passed.
        age_inc = (&debounce_age_reg) ? debounce_age_reg
                                      : debounce_age_reg + 8'd1;
        take_level = (age_inc >= cfg.debounce_ticks)
                     && (button_level != debounced_level_reg);
        debounce_age_next = take_level ? '0 : age_inc;
        if (take_level)
            debounced_level_next = button_level;
        pressed_now = take_level && button_level;

        if (mode_coil)
        begin
            // Impulse switch: fire a pulse on a mismatch unless held off or busy.
            if ((switch_coil != debounced_level_next) && !holding_off_reg
                && !pulsing_reg)
            begin
                drive_level_next   = 1'b1;
                pulsing_next       = 1'b1;
                pulse_elapsed_next = '0;
            end
        end
        else
        begin
            if (switch_coil != relay_on_reg)
            begin
                relay_on_next    = switch_coil;
                drive_level_next = switch_coil;
            end
            // A press toggles the relay after the command has been applied.
            if (pressed_now)
            begin
                relay_on_next    = !relay_on_next;
                drive_level_next = relay_on_next;
                write_valid      = 1'b1;
                write_value      = relay_on_next;
            end
        end

        // A pulse ends when its time is up or its timer has saturated.
        if (pulsing_next
            && ((CMP_W'(pulse_elapsed_next) >= CMP_W'(cfg.pulse_ticks))
                || (&pulse_elapsed_next)))
        begin
            drive_level_next     = 1'b0;
            pulsing_next         = 1'b0;
            holding_off_next     = 1'b1;
            holdoff_elapsed_next = '0;
        end
        if (holding_off_next
            && ((CMP_W'(holdoff_elapsed_next) >= CMP_W'(cfg.holdoff_ticks))
                || (&holdoff_elapsed_next)))
            holding_off_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounced_level_reg <= 1'b0;
            debounce_age_reg    <= '0;
            relay_on_reg        <= 1'b0;
            drive_level_reg     <= 1'b0;
            pulsing_reg         <= 1'b0;
            pulse_elapsed_reg   <= '0;
            holding_off_reg     <= 1'b0;
            holdoff_elapsed_reg <= '0;
        end
        else if (step_en)
        begin
            debounced_level_reg <= debounced_level_next;
            debounce_age_reg    <= debounce_age_next;
            relay_on_reg        <= relay_on_next;
            drive_level_reg     <= drive_level_next;
            pulsing_reg         <= pulsing_next;
            pulse_elapsed_reg   <= pulse_elapsed_next;
            holding_off_reg     <= holding_off_next;
            holdoff_elapsed_reg <= holdoff_elapsed_next;
        end
    end

    assign res.relay_drive      = drive_level_next;
    assign res.coil_write_valid = write_valid;
    assign res.coil_write_value = write_value;

    assign status.pulsing     = pulsing_reg;
    assign status.holding_off = holding_off_reg;

endmodule

`default_nettype wire

// ===== design/impulse_relay_output_controller_unit.sv =====
// Top level of the impulse relay output controller: input register, step logic, result register.
// Depends on iroc_pkg, iroc_cfg and iroc_step.
//
// Usage: one input transfer per millisecond tick carries switch_coil, mode_coil and
// the raw button_level. Each accepted item yields exactly one result transfer with
// relay_drive, coil_write_valid and coil_write_value. Both channels use valid/ready.
// An item is captured in the input register at its transfer, and its result is
// captured in the result register at the next edge at which that register is free
// or being emptied. Throughput is one item per clock cycle while out_ready stays high;
// the combinational step logic between the two registers sets that rate.
// When the receiver stalls, the result register holds its transfer and the input
// register holds one more item; in_ready falls only when both are full and out_ready
// is low. Reset clears both valid flags, all controller state, and loads the
// configuration registers with their defaults (debounce 25, pulse 200, holdoff 200
// ticks). Configuration is written through cfg_write_en, cfg_index and cfg_data, and
// takes effect at once; it is meant to be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module impulse_relay_output_controller_unit #(
    parameter int unsigned TIMER_BITS = iroc_pkg::TIMER_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              switch_coil,
    input  wire logic                              mode_coil,
    input  wire logic                              button_level,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   relay_drive,
    output logic                                   coil_write_valid,
    output logic                                   coil_write_value,
    input  wire logic                              cfg_write_en,
    input  wire logic [iroc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [iroc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    iroc_pkg::cfg_t    cfg;
    iroc_pkg::res_t    step_res;
    iroc_pkg::status_t status;

    logic           in_vld_reg;
    logic           switch_coil_reg;
    logic           mode_coil_reg;
    logic           button_level_reg;
    logic           out_vld_reg;
    iroc_pkg::res_t res_reg;
    logic           advance;

    // The item in the input register moves on whenever the result register can take it.
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    iroc_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    iroc_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (advance),
        .switch_coil  (switch_coil_reg),
        .mode_coil    (mode_coil_reg),
        .button_level (button_level_reg),
        .cfg          (cfg),
        .res          (step_res),
        .status       (status)
    );

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    // Input payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            switch_coil_reg  <= switch_coil;
            mode_coil_reg    <= mode_coil;
            button_level_reg <= button_level;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= step_res;
    end

    assign out_valid        = out_vld_reg;
    assign relay_drive      = res_reg.relay_drive;
    assign coil_write_valid = res_reg.coil_write_valid;
    assign coil_write_value = res_reg.coil_write_value;

    // A pulse and its holdoff never run at the same time.
    a_pulse_holdoff_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(status.pulsing && status.holding_off)
    ) else $error("pulse and holdoff active together");

    // The coil write value is only ever set together with the write flag.
    a_write_value_qualified: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && coil_write_value) |-> coil_write_valid
    ) else $error("coil write value without write valid");

    // Back-pressure on the input only arises from a stalled, full result register.
    a_ready_only_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready && in_vld_reg)
    ) else $error("input stalled without a downstream stall");

    // A state update happens only when a result is loaded.
    a_step_loads_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance |=> out_valid
    ) else $error("step taken but no result presented");

endmodule

`default_nettype wire

// ===== sim/impulse_relay_output_controller_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for impulse_relay_output_controller_unit: directed and random ticks
// are compared with an in-bench model of the controller. Depends on iroc_pkg and the RTL.

module impulse_relay_output_controller_unit_test;
    import iroc_pkg::*;

    localparam int TIMER_BITS = TIMER_BITS_DEFAULT;
    localparam logic [TIMER_BITS-1:0] TIMER_FULL = '1;
    localparam logic [DEBOUNCE_W-1:0] AGE_FULL = '1;
    // Index 3 decodes to no register; writes to it must leave everything alone.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    // Clock cycles waited after a drain so that the block has settled.
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT = 5000;
    localparam int IDLE_PERCENT = 9;

    // Clock and reset. Reset is asserted from time zero.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Input channel.
    logic in_valid = 1'b0;
    logic in_ready;
    logic switch_coil = 1'b0;
    logic mode_coil = 1'b0;
    logic button_level = 1'b0;

    // Result channel.
    logic out_valid;
    logic out_ready = 1'b0;
    logic relay_drive;
    logic coil_write_valid;
    logic coil_write_value;

    // Register write port.
    logic cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_DEBOUNCE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register copies held by the model.
    logic [DEBOUNCE_W-1:0] lockout_ticks;
    logic [TICKS_W-1:0] pulse_len;
    logic [TICKS_W-1:0] holdoff_len;

    // Controller state held by the model.
    logic sense_level;
    logic [DEBOUNCE_W-1:0] lockout_age;
    logic relay_on;
    logic drive_level;
    logic pulse_active;
    logic [TIMER_BITS-1:0] pulse_age;
    logic holdoff_active;
    logic [TIMER_BITS-1:0] holdoff_age;

    // Results predicted for accepted ticks, oldest first.
    res_t predicted_outputs[$];

    // While set, neither side idles: this gives a long back-to-back stretch.
    bit steady_run = 1'b0;

    int error_count = 0;
    int ticks_sent = 0;
    int results_checked = 0;
    int settings_applied = 0;

    impulse_relay_output_controller_unit #(
        .TIMER_BITS(TIMER_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .switch_coil(switch_coil),
        .mode_coil(mode_coil),
        .button_level(button_level),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .relay_drive(relay_drive),
        .coil_write_valid(coil_write_valid),
        .coil_write_value(coil_write_value),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Prints one line per mismatch and keeps count of them.
    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("[%0t] MISMATCH %s: got %b, expected %b", $realtime, what, got, want);
        error_count++;
    endtask

    // Puts the model into its post-reset state, registers included.
    function automatic void reset_controller_model();
        lockout_ticks = DEBOUNCE_RESET;
        pulse_len = PULSE_RESET;
        holdoff_len = HOLDOFF_RESET;
        sense_level = 1'b0;
        lockout_age = '0;
        relay_on = 1'b0;
        drive_level = 1'b0;
        pulse_active = 1'b0;
        pulse_age = '0;
        holdoff_active = 1'b0;
        holdoff_age = '0;
    endfunction

    // A running timer counts as expired once it reaches its limit, or once it has
    // saturated at all ones, whichever comes first.
    function automatic logic timer_done(input logic [TIMER_BITS-1:0] age,
                                        input logic [TICKS_W-1:0] limit);
        return (age >= limit) || (age == TIMER_FULL);
    endfunction

    // Advances the model by one millisecond tick and returns the result it produces.
    // The order matters: timers first, then the debounce, then the mode logic, and
    // finally the end-of-pulse and end-of-holdoff checks.
    function automatic res_t step_controller(input logic coil, input logic mode,
                                             input logic pin);
        res_t outcome;
        logic pressed;
        outcome = '0;
        pressed = 1'b0;

        if (pulse_active && pulse_age != TIMER_FULL)
            pulse_age = pulse_age + 1'b1;
        if (holdoff_active && holdoff_age != TIMER_FULL)
            holdoff_age = holdoff_age + 1'b1;

        // Lockout debounce: a new level is taken over only once the age has caught
        // up with the lockout; a rising level counts as a press.
        if (lockout_age != AGE_FULL)
            lockout_age = lockout_age + 1'b1;
        if (lockout_age >= lockout_ticks && pin != sense_level)
        begin
            sense_level = pin;
            lockout_age = '0;
            pressed = pin;
        end

        if (mode)
        begin
            // Impulse switch: a mismatch fires a pulse unless one is running or
            // the holdoff after the last one is still in force.
            if (coil != sense_level && !holdoff_active && !pulse_active)
            begin
                drive_level = 1'b1;
                pulse_active = 1'b1;
                pulse_age = '0;
            end
        end
        else
        begin
            // Direct relay: the command goes first, then a press toggles the
            // output and asks for the coil to be rewritten.
            if (coil && !relay_on)
            begin
                drive_level = 1'b1;
                relay_on = 1'b1;
            end
            else if (!coil && relay_on)
            begin
                drive_level = 1'b0;
                relay_on = 1'b0;
            end
            if (pressed)
            begin
                relay_on = !relay_on;
                drive_level = relay_on;
                outcome.coil_write_valid = 1'b1;
                outcome.coil_write_value = relay_on;
            end
        end

        // A pulse left running across a change to relay mode still ends here.
        if (pulse_active && timer_done(pulse_age, pulse_len))
        begin
            drive_level = 1'b0;
            pulse_active = 1'b0;
            holdoff_active = 1'b1;
            holdoff_age = '0;
        end
        if (holdoff_active && timer_done(holdoff_age, holdoff_len))
            holdoff_active = 1'b0;

        outcome.relay_drive = drive_level;
        return outcome;
    endfunction

    // Writes one register. Called only while the block is idle, just after an edge.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        case (index)
            REG_DEBOUNCE: lockout_ticks = value[DEBOUNCE_W-1:0];
            REG_PULSE: pulse_len = value[TICKS_W-1:0];
            REG_HOLDOFF: holdoff_len = value[TICKS_W-1:0];
            default: ;
        endcase
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [DEBOUNCE_W-1:0] lockout,
                                 input logic [TICKS_W-1:0] pulse,
                                 input logic [TICKS_W-1:0] holdoff);
        // The upper data bits of the debounce write are random: only the low byte counts.
        write_register(REG_DEBOUNCE, {8'($urandom), lockout});
        write_register(REG_PULSE, pulse);
        write_register(REG_HOLDOFF, holdoff);
        settings_applied++;
    endtask

    // Offers one tick on the input channel and waits for its transfer. Valid is left
    // high afterwards so that back-to-back ticks never see it dropped and raised in
    // one time step; a gap lowers it in the step after the previous transfer.
    task automatic send_tick(input logic coil, input logic mode, input logic pin);
        int gap;
        gap = 0;
        if (!steady_run)
            while ($urandom_range(0, 99) < IDLE_PERCENT)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        switch_coil <= coil;
        mode_coil <= mode;
        button_level <= pin;
        do
            @(posedge clk);
        while (!in_ready);
        predicted_outputs.push_back(step_controller(coil, mode, pin));
        ticks_sent++;
    endtask

    // Stops offering ticks and waits until every predicted result has been seen,
    // then lets the block settle. Anything still missing after the limit is a failure.
    task automatic wait_until_drained();
        int waited;
        res_t missing;
        waited = 0;
        in_valid <= 1'b0;
        while (predicted_outputs.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        while (predicted_outputs.size() != 0)
        begin
            missing = predicted_outputs.pop_front();
            report_mismatch("result never arrived (relay_drive)", 1'bx, missing.relay_drive);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The receiver stalls at random, except during the steady stretch.
    always @(posedge clk)
        out_ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PERCENT);

    // Every result transfer is matched against the oldest prediction, field by field.
    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_outputs.size() == 0)
            begin
                report_mismatch("result with no tick outstanding", relay_drive, 1'bx);
            end
            else
            begin
                want = predicted_outputs.pop_front();
                results_checked++;
                if (relay_drive !== want.relay_drive)
                    report_mismatch("relay_drive", relay_drive, want.relay_drive);
                if (coil_write_valid !== want.coil_write_valid)
                    report_mismatch("coil_write_valid", coil_write_valid,
                                    want.coil_write_valid);
                if (coil_write_value !== want.coil_write_value)
                    report_mismatch("coil_write_value", coil_write_value,
                                    want.coil_write_value);
            end
        end
    end

    // Reset values: the relay follows the command, and a press that comes before the
    // default lockout of 25 ticks has run out is ignored.
    task automatic test_reset_defaults();
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        wait_until_drained();
    endtask

    // Relay mode with no lockout: command on and off, presses that toggle the output
    // and write the coil back, a held button and a release.
    task automatic test_relay_mode();
        apply_setting(8'd0, 16'd200, 16'd200);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
        wait_until_drained();
    endtask

    // Impulse switch mode: zero pulse and holdoff lengths, a short pulse with a
    // request while it runs and during the holdoff, and a change to relay mode while
    // a pulse is still running. A write to the spare index must change nothing.
    task automatic test_switch_mode();
        apply_setting(8'd0, 16'd0, 16'd0);
        write_register(REG_SPARE, 16'hFFFF);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);
        wait_until_drained();
        apply_setting(8'd0, 16'd2, 16'd3);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        wait_until_drained();
    endtask

    // One stretch of random ticks under the current setting. Most ticks are well
    // formed: slowly changing levels, so that debounce, pulses and holdoffs run their
    // course; about one in ten is pure noise. Optionally pauses half way until every
    // result is back.
    task automatic run_random_ticks(input int count, input int pin_flip_pct,
                                    input bit pause_midway);
        logic coil;
        logic mode;
        logic pin;
        coil = 1'($urandom);
        mode = 1'($urandom);
        pin = 1'($urandom);
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                wait_until_drained();
            if ($urandom_range(0, 99) < 10)
            begin
                coil = 1'($urandom);
                mode = 1'($urandom);
                pin = 1'($urandom);
            end
            else
            begin
                if ($urandom_range(0, 99) < pin_flip_pct)
                    pin = !pin;
                if ($urandom_range(0, 99) < 8)
                    coil = !coil;
                if ($urandom_range(0, 99) < 3)
                    mode = !mode;
            end
            send_tick(coil, mode, pin);
        end
        wait_until_drained();
    endtask

    // Random ticks under several settings, the extremes of every register included.
    task automatic test_random_settings();
        apply_setting(DEBOUNCE_RESET, PULSE_RESET, HOLDOFF_RESET);
        run_random_ticks(250, 5, 1'b0);

        apply_setting(8'd0, 16'd0, 16'd0);
        run_random_ticks(250, 30, 1'b1);

        // Longest lockout: the age has to saturate before the pin is sampled again.
        apply_setting(8'd255, 16'hFFFF, 16'hFFFF);
        run_random_ticks(300, 20, 1'b0);

        // Back-to-back transfers on both sides for the whole of this stretch.
        steady_run = 1'b1;
        apply_setting(8'd1, 16'd1, 16'd0);
        run_random_ticks(250, 25, 1'b0);
        steady_run = 1'b0;

        apply_setting(8'($urandom_range(0, 6)), 16'($urandom_range(0, 12)),
                      16'($urandom_range(0, 12)));
        run_random_ticks(250, 15, 1'b1);

        apply_setting(8'($urandom_range(0, 6)), 16'($urandom_range(0, 12)),
                      16'($urandom_range(0, 12)));
        run_random_ticks(200, 15, 1'b0);

        apply_setting(8'd3, 16'hFFFF, 16'd0);
        run_random_ticks(150, 20, 1'b0);

        apply_setting(8'd0, 16'd5, 16'hFFFF);
        run_random_ticks(150, 20, 1'b0);
    endtask

    initial
    begin
        reset_controller_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_relay_mode();
        test_switch_mode();
        test_random_settings();
        wait_until_drained();

        $display("Sent %0d ticks and checked %0d results under %0d register settings,",
                 ticks_sent, results_checked, settings_applied);
        $display("covering relay and impulse modes, debounce lockout, pulses and holdoffs.");
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: the full run needs well under a tenth of this time.
    initial
    begin
        #2000000;
        $display("Timeout with %0d results still outstanding", predicted_outputs.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== impulse_relay_output_controller_unit.f =====
design/iroc_pkg.sv
design/iroc_cfg.sv
design/iroc_step.sv
design/impulse_relay_output_controller_unit.sv
sim/impulse_relay_output_controller_unit_test.sv
